[rtl/bls_pkg.sv]
// shared types, constants and the log mantissa table for the band level smoother
`timescale 1ns / 1ps
package bls_pkg;

	typedef logic [4:0]  band_t;
	typedef logic [15:0] level_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_RISE      = 2'd0,
		CFG_FALL      = 2'd1,
		CFG_PEAK_STEP = 2'd2
	} cfg_idx_t;

	localparam level_t RISE_RESET      = 16'd39322;
	localparam level_t FALL_RESET      = 16'd11796;
	localparam level_t PEAK_STEP_RESET = 16'd917;

	// 65536 * 20*log10(2) / 60
	localparam logic [12:0] LOG_SCALE = 13'd6576;

	// store write port, also kept as the last-write record
	typedef struct packed {
		logic   en;
		band_t  band;
		level_t smooth;
		level_t peak;
	} bls_wr_t;

	// round(256 * log2(1 + k/16))
	function automatic logic [7:0] mant_lut(input logic [3:0] k);
		logic [7:0] v;
		case (k)
			4'd0:    v = 8'd0;
			4'd1:    v = 8'd22;
			4'd2:    v = 8'd44;
			4'd3:    v = 8'd63;
			4'd4:    v = 8'd82;
			4'd5:    v = 8'd100;
			4'd6:    v = 8'd118;
			4'd7:    v = 8'd134;
			4'd8:    v = 8'd150;
			4'd9:    v = 8'd165;
			4'd10:   v = 8'd179;
			4'd11:   v = 8'd193;
			4'd12:   v = 8'd207;
			4'd13:   v = 8'd220;
			4'd14:   v = 8'd232;
			default: v = 8'd244;
		endcase
		return v;
	endfunction

endpackage

[rtl/bls_level.sv]
// magnitude to log level: leading one, mantissa table, dB scale and clamp
`timescale 1ns / 1ps
module bls_level (
	input  bls_pkg::level_t mag,
	output bls_pkg::level_t level
);
	import bls_pkg::*;

	logic [3:0]  lead;
	logic [15:0] norm;
	logic [3:0]  frac;
	logic [4:0]  whole;
	logic [12:0] deficit;
	logic [25:0] prod;
	logic [25:0] rounded;
	logic [17:0] drop;

	always_comb begin
		lead = 4'd0;
		for (int i = 0; i < 16; i++) begin
			if (mag[i]) begin
				lead = 4'(i);
			end
		end
	end

	// bring the leading one to bit 15, next four bits are the mantissa index
	assign norm    = mag << (4'd15 - lead);
	assign frac    = norm[14:11];
	assign whole   = 5'd16 - {1'b0, lead};
	assign deficit = {whole, 8'd0} - {5'd0, mant_lut(frac)};
	assign prod    = 26'(deficit) * 26'(LOG_SCALE);
	assign rounded = prod + 26'd128;
	assign drop    = rounded[25:8];

	always_comb begin
		if (mag == 16'd0) begin
			level = 16'd0;
		end else if (drop[17:16] != 2'd0) begin
			level = 16'd0;
		end else if (drop == 18'd0) begin
			level = 16'hffff;
		end else begin
			level = 16'(17'h10000 - drop[16:0]);
		end
	end

endmodule

[rtl/bls_store.sv]
// per-band smoothed and peak memories with valid bits and last-write bypass
`timescale 1ns / 1ps
module bls_store #(
	parameter int NUM_BANDS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  bls_pkg::bls_wr_t wr,
	input  bls_pkg::band_t   rd_band,
	input  bls_pkg::band_t   cur_band,
	output bls_pkg::level_t  cur_smooth,
	output bls_pkg::level_t  cur_peak
);
	import bls_pkg::*;

	localparam int AW = $clog2(NUM_BANDS);

	logic [15:0]    smooth_mem [NUM_BANDS];
	logic [15:0]    peak_mem   [NUM_BANDS];
	logic           vld_q      [NUM_BANDS];
	level_t         rd_smooth_q;
	level_t         rd_peak_q;
	bls_wr_t        last_q;
	logic [8:0]     wr_ext;
	logic [8:0]     rd_ext;
	logic [8:0]     cur_ext;
	logic [AW-1:0]  waddr;
	logic [AW-1:0]  raddr;
	logic [AW-1:0]  caddr;
	logic           cur_vld;

	assign wr_ext  = {4'd0, wr.band};
	assign rd_ext  = {4'd0, rd_band};
	assign cur_ext = {4'd0, cur_band};
	assign waddr   = wr_ext[AW-1:0];
	assign raddr   = rd_ext[AW-1:0];
	assign caddr   = cur_ext[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			smooth_mem[waddr] <= wr.smooth;
			peak_mem[waddr]   <= wr.peak;
		end
		rd_smooth_q <= smooth_mem[raddr];
		rd_peak_q   <= peak_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BANDS; i++) begin
				vld_q[i] <= 1'b0;
			end
			last_q <= '0;
		end else begin
			if (wr.en) begin
				vld_q[waddr] <= 1'b1;
			end
			last_q <= wr;
		end
	end

	assign cur_vld = (cur_ext < 9'(NUM_BANDS)) && vld_q[caddr];

	// read data misses the write made at the same edge
	always_comb begin
		if (last_q.en && last_q.band == cur_band) begin
			cur_smooth = last_q.smooth;
			cur_peak   = last_q.peak;
		end else if (cur_vld) begin
			cur_smooth = rd_smooth_q;
			cur_peak   = rd_peak_q;
		end else begin
			cur_smooth = 16'd0;
			cur_peak   = 16'd0;
		end
	end

endmodule

[rtl/band_level_smoother_peak_hold_unit.sv]
// top level: band level smoother with peak hold, four-register pipeline
// a result passes through s1, s2, s3 and the output register; throughput is one item per
// cycle unless stalled; bubbles collapse, so items are taken while a result waits
// rate is set by the store read-modify-write, closed by forwarding from stage 3
// reset: asynchronous, clears stage valids, store valid bits and registers to defaults
// stores read as zero after reset through per-band valid bits, no clearing pass
`timescale 1ns / 1ps
module band_level_smoother_peak_hold_unit #(
	parameter int NUM_BANDS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	// item channel
	input  logic            item_valid,
	output logic            item_stall,
	input  bls_pkg::band_t  band_index,
	input  bls_pkg::level_t band_magnitude,
	// result channel
	output logic            result_valid,
	input  logic            result_stall,
	output bls_pkg::band_t  out_band,
	output bls_pkg::level_t smoothed_level,
	output bls_pkg::level_t peak_level,
	// configuration channel
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [1:0]      cfg_index,
	input  logic [15:0]     cfg_data
);
	import bls_pkg::*;

	// configuration registers
	level_t rise_q;
	level_t fall_q;
	level_t step_q;

	// stage valids and ready chain
	logic v_s1, v_s2, v_s3;
	logic rdy_o, rdy_s3, rdy_s2, rdy_s1;

	// stage payloads
	band_t  band_s1;
	level_t mag_s1;
	band_t  band_s2;
	level_t n_s2;
	band_t  band_s3;
	logic   inr_s3;
	level_t s_new_s3;
	level_t p_old_s3;

	// output register
	logic   out_valid_q;
	band_t  out_band_q;
	level_t out_smooth_q;
	level_t out_peak_q;

	// datapath
	level_t  n_s1;
	level_t  st_smooth;
	level_t  st_peak;
	level_t  s_cur;
	level_t  p_cur;
	logic    fwd_s3;
	logic    rise;
	level_t  diff;
	level_t  wgt;
	logic [31:0] prod;
	logic [32:0] rounded;
	level_t  delta;
	level_t  s_new;
	level_t  p_new;
	logic    inr_s2;
	band_t   rd_band;
	bls_wr_t wr;

	function automatic logic in_range(input band_t b);
		return {4'd0, b} < 9'(NUM_BANDS);
	endfunction

	// configuration, always ready; writes beyond the list fall through
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_q <= RISE_RESET;
			fall_q <= FALL_RESET;
			step_q <= PEAK_STEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_RISE:      rise_q <= cfg_data;
				CFG_FALL:      fall_q <= cfg_data;
				CFG_PEAK_STEP: step_q <= cfg_data;
				default:       ;
			endcase
		end
	end

	// a stage takes a new item when it is empty or its item moves on
	assign rdy_o  = !out_valid_q || !result_stall;
	assign rdy_s3 = !v_s3 || rdy_o;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign item_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= item_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_o)  out_valid_q <= v_s3;
		end
	end

	// stage 1: input register, log level
	always_ff @(posedge clk) begin
		if (rdy_s1 && item_valid) begin
			band_s1 <= band_index;
			mag_s1  <= band_magnitude;
		end
	end

	bls_level u_level (
		.mag   (mag_s1),
		.level (n_s1)
	);

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			band_s2 <= band_s1;
			n_s2    <= n_s1;
		end
	end

	// store read runs every cycle for the band that sits in s2 next cycle
	assign rd_band = rdy_s2 ? band_s1 : band_s2;

	assign wr.en     = v_s3 && rdy_o && inr_s3;
	assign wr.band   = band_s3;
	assign wr.smooth = s_new_s3;
	assign wr.peak   = p_new;

	bls_store #(
		.NUM_BANDS (NUM_BANDS)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.rd_band    (rd_band),
		.cur_band   (band_s2),
		.cur_smooth (st_smooth),
		.cur_peak   (st_peak)
	);

	// stage 2: smoothing; the item in s3 is newer than anything in the store
	assign fwd_s3 = v_s3 && (band_s3 == band_s2);
	assign s_cur  = fwd_s3 ? s_new_s3 : st_smooth;
	// s3 leaves at the same edge s2 moves in, so its new peak is what s2 must see
	assign p_cur  = fwd_s3 ? p_new : st_peak;
	assign inr_s2 = in_range(band_s2);

	assign rise    = n_s2 > s_cur;
	assign diff    = rise ? (n_s2 - s_cur) : (s_cur - n_s2);
	assign wgt     = rise ? rise_q : fall_q;
	assign prod    = 32'(diff) * 32'(wgt);
	assign rounded = 33'(prod) + 33'd32768;
	// rounded weight product never exceeds the distance, so 16 bits hold it
	assign delta   = rounded[31:16];
	assign s_new   = rise ? (s_cur + delta) : (s_cur - delta);

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			band_s3  <= band_s2;
			inr_s3   <= inr_s2;
			s_new_s3 <= s_new;
			p_old_s3 <= p_cur;
		end
	end

	// stage 3: peak hold, jump up or fall by the step floored at zero
	always_comb begin
		if (s_new_s3 >= p_old_s3) begin
			p_new = s_new_s3;
		end else if (p_old_s3 > step_q) begin
			p_new = p_old_s3 - step_q;
		end else begin
			p_new = 16'd0;
		end
	end

	// output register; bands past the store report zero levels
	always_ff @(posedge clk) begin
		if (rdy_o && v_s3) begin
			out_band_q   <= band_s3;
			out_smooth_q <= inr_s3 ? s_new_s3 : 16'd0;
			out_peak_q   <= inr_s3 ? p_new : 16'd0;
		end
	end

	assign result_valid   = out_valid_q;
	assign out_band       = out_band_q;
	assign smoothed_level = out_smooth_q;
	assign peak_level     = out_peak_q;

`ifndef SYNTHESIS
	// a full pipeline behind a stalled result must hold off new items
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && result_valid && result_stall) |-> item_stall)
		else $error("item taken with full pipeline and stalled result");

	// every store write shows up as the next result with the same band and level
	a_write_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |=> (result_valid && out_band == $past(band_s3)
			&& smoothed_level == $past(s_new_s3) && peak_level == $past(p_new)))
		else $error("store write not matched by result register");

	// results for bands outside the store carry zero levels
	a_out_of_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !in_range(out_band)) |-> (smoothed_level == 16'd0
			&& peak_level == 16'd0))
		else $error("out-of-range band result not zero");
`endif

endmodule

[tb/tb_band_level_smoother_peak_hold_unit.sv]
// testbench for the band level smoother with peak hold: directed and random items
`timescale 1ns / 1ps
module tb_band_level_smoother_peak_hold_unit;
	import bls_pkg::*;

	localparam int NUM_BANDS = 32;

	// register values after reset
	localparam level_t DEF_RISE      = 16'd39322;
	localparam level_t DEF_FALL      = 16'd11796;
	localparam level_t DEF_PEAK_STEP = 16'd917;

	// an index past the register list, writes to it must not land anywhere
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	// dB slope: 65536 * 20*log10(2) / 60
	localparam logic [31:0] DB_SLOPE = 32'd6576;

	// round(256 * log2(1 + k/16)), entry k at bits [8k +: 8]
	localparam logic [127:0] LOG2_FRAC = {
		8'd244, 8'd232, 8'd220, 8'd207, 8'd193, 8'd179, 8'd165, 8'd150,
		8'd134, 8'd118, 8'd100, 8'd82,  8'd63,  8'd44,  8'd22,  8'd0
	};

	// sized from the slowest legal run, then taken many times over
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		band_t  band;
		level_t smooth;
		level_t peak;
	} band_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	band_t       band_index = '0;
	level_t      band_magnitude = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	band_t       out_band;
	level_t      smoothed_level;
	level_t      peak_level;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// predictor state: per-band stores and the register copies
	level_t smooth_mem [NUM_BANDS];
	level_t peak_mem [NUM_BANDS];
	level_t rise_w = DEF_RISE;
	level_t fall_w = DEF_FALL;
	level_t step_w = DEF_PEAK_STEP;

	// results predicted at item acceptance, oldest first
	band_result_t pending_results [$];
	band_result_t head_result;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int errors = 0;
	int items_sent = 0;
	int results_checked = 0;
	int reg_writes = 0;
	int cycles = 0;

	band_level_smoother_peak_hold_unit #(
		.NUM_BANDS(NUM_BANDS)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.band_index    (band_index),
		.band_magnitude(band_magnitude),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.out_band      (out_band),
		.smoothed_level(smoothed_level),
		.peak_level    (peak_level),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timed out after %0d cycles, %0d results still pending",
				$time, cycles, pending_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// magnitude to log level: leading one plus 4 mantissa bits, -60..0 dB onto 0..1
	function automatic level_t magnitude_to_level(input level_t mag);
		int          lead;
		logic [19:0] widened;
		logic [3:0]  frac;
		logic [31:0] deficit;
		logic [31:0] drop;
		lead = 0;
		for (int i = 0; i < 16; i++) begin
			if (mag[i])
				lead = i;
		end
		// zero stands for the -60 dB floor
		if (mag == '0)
			return '0;
		// bits just below the leading one, zero-filled under bit 4
		widened = {mag, 4'b0000};
		frac = widened[lead +: 4];
		deficit = (16 - lead) * 256 - LOG2_FRAC[frac * 8 +: 8];
		drop = (deficit * DB_SLOPE + 32'd128) >> 8;
		if (drop >= 32'd65536)
			return '0;
		if (drop == '0)
			return 16'hFFFF;
		return 16'(17'h10000 - drop[16:0]);
	endfunction

	// one band update: smoothing toward the new level, then the peak hold
	function automatic band_result_t predict_band_update(input band_t band, input level_t mag);
		band_result_t res;
		level_t       lvl;
		level_t       s;
		level_t       p;
		logic [32:0]  prod;
		lvl = magnitude_to_level(mag);
		s = smooth_mem[band];
		p = peak_mem[band];
		if (lvl > s) begin
			prod = (lvl - s) * rise_w + 33'd32768;
			s = s + prod[31:16];
		end else begin
			prod = (s - lvl) * fall_w + 33'd32768;
			s = s - prod[31:16];
		end
		if (s >= p)
			p = s;
		else if (p > step_w)
			p = p - step_w;
		else
			p = '0;
		smooth_mem[band] = s;
		peak_mem[band] = p;
		res.band = band;
		res.smooth = s;
		res.peak = p;
		return res;
	endfunction

	// result side: compare each accepted result with the oldest prediction, then pick the next stall
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result with nothing pending, band %0d smoothed %h peak %h",
					$time, out_band, smoothed_level, peak_level);
			end else begin
				head_result = pending_results.pop_front();
				results_checked++;
				if (out_band !== head_result.band) begin
					errors++;
					$display("%0t: out_band expected %0d actual %0d",
						$time, head_result.band, out_band);
				end
				if (smoothed_level !== head_result.smooth) begin
					errors++;
					$display("%0t: band %0d smoothed_level expected %h actual %h",
						$time, head_result.band, head_result.smooth, smoothed_level);
				end
				if (peak_level !== head_result.peak) begin
					errors++;
					$display("%0t: band %0d peak_level expected %h actual %h",
						$time, head_result.band, head_result.peak, peak_level);
				end
			end
		end
		result_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// offer one item with a random lead-in gap; predict once it is taken
	task automatic send_item(input band_t band, input level_t mag);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		band_index <= band;
		band_magnitude <= mag;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		pending_results.insert(pending_results.size(), predict_band_update(band, mag));
		items_sent++;
	endtask

	// take valid down and wait until every predicted result has come back
	task automatic drain_results();
		item_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// one register write; valid is left high for the caller to drop
	task automatic write_register(input logic [1:0] idx, input level_t data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_RISE:      rise_w = data;
			CFG_FALL:      fall_w = data;
			CFG_PEAK_STEP: step_w = data;
			default:       ;
		endcase
		reg_writes++;
	endtask

	// new weights only once the pipeline is empty; optionally poke the unused index after
	task automatic apply_weights(input level_t rise, input level_t fall, input level_t step,
			input bit poke_unused);
		logic [31:0] junk;
		junk = $urandom;
		drain_results();
		write_register(CFG_RISE, rise);
		write_register(CFG_FALL, fall);
		write_register(CFG_PEAK_STEP, step);
		if (poke_unused)
			write_register(CFG_UNUSED, junk[15:0]);
		cfg_valid <= 1'b0;
	endtask

	function automatic level_t random_magnitude();
		int          pick;
		int          lead;
		logic [31:0] r;
		pick = $urandom_range(99);
		lead = $urandom_range(15);
		r = $urandom;
		if (pick < 10)
			return '0;
		if (pick < 20)
			return 16'hFFFF;
		if (pick < 40)
			return r[15:0];
		// leading one at a chosen position, random bits below it
		return (16'h1 << lead) | (r[15:0] & ((16'h1 << lead) - 16'h1));
	endfunction

	// reset values of the registers and cleared stores, no writes yet
	task automatic test_reset_defaults();
		send_item(5'd0, 16'hFFFF);   // full scale into a cleared band
		send_item(5'd0, 16'hFFFF);   // same band back to back
		send_item(5'd0, 16'h0000);   // silence: slow fall, peak steps down
		send_item(5'd0, 16'h0000);
		send_item(5'd0, 16'h0000);
		send_item(5'd31, 16'h0001);  // smallest nonzero magnitude, top band
		send_item(5'd31, 16'h0000);
		send_item(5'd1, 16'h0003);   // leading one below bit 4
		send_item(5'd1, 16'h0005);
		send_item(5'd2, 16'h0010);   // leading one exactly at bit 4
		send_item(5'd3, 16'h8000);
		send_item(5'd3, 16'h7FFF);
		send_item(5'd4, 16'h00FF);
		send_item(5'd4, 16'hAAAA);
	endtask

	// weight and step extremes, plus a write to the unused index
	task automatic test_register_extremes();
		apply_weights(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		send_item(5'd5, 16'hFFFF);   // near-complete jump up in one item
		send_item(5'd5, 16'h0000);   // near-complete drop, peak floored at zero
		send_item(5'd5, 16'h1234);
		apply_weights(16'h0000, 16'h0000, 16'h0000, 1'b1);
		send_item(5'd5, 16'hFFFF);   // zero weights freeze the level
		send_item(5'd5, 16'h0000);   // zero step holds the peak
		send_item(5'd7, 16'h4000);
		apply_weights(16'hFFFF, 16'h0000, 16'h0001, 1'b0);
		send_item(5'd8, 16'h0100);
		send_item(5'd8, 16'h0001);   // level never falls, peak follows
		send_item(5'd8, 16'hFFFF);
	endtask

	// random traffic with hot bands, same-band runs and attack/release bursts
	task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int n_items,
			input level_t rise, input level_t fall, input level_t step, input bit poke_unused);
		int     sent;
		int     pick;
		int     burst_len;
		band_t  band;
		band_t  last_band;
		logic [31:0] r;
		sent = 0;
		last_band = '0;
		apply_weights(rise, fall, step, poke_unused);
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			r = $urandom;
			// repeats of the previous band hit the store forwarding path
			if (pick < 25)
				band = last_band;
			else if (pick < 55)
				band = {3'd0, r[1:0]};
			else
				band = r[4:0];
			if ($urandom_range(99) < 6) begin
				// one loud item then a run of near silence drives the peak down toward its floor
				burst_len = $urandom_range(6, 20);
				send_item(band, 16'hFFFF - r[15:8]);
				repeat (burst_len)
					send_item(band, {14'd0, r[17:16]});
				sent += burst_len + 1;
			end else begin
				send_item(band, random_magnitude());
				sent++;
			end
			last_band = band;
		end
	endtask

	initial begin
		logic [31:0] ra;
		logic [31:0] rb;
		logic [31:0] rc;
		ra = $urandom;
		rb = $urandom;
		rc = $urandom;
		for (int i = 0; i < NUM_BANDS; i++) begin
			smooth_mem[i] = '0;
			peak_mem[i] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// sender idles 30 in 100, receiver 55 in 100
		send_idle_pct = 30;
		recv_idle_pct = 55;
		test_reset_defaults();
		test_register_extremes();
		test_random_traffic(30, 55, 180, ra[15:0], ra[31:16], rb[15:0], 1'b0);

		// roles swapped; slow rise, fast fall and a big step reach the peak floor often
		test_random_traffic(55, 30, 180, {2'b00, rb[29:16]}, 16'h8000 | rc[15:0],
			16'h1000 | rc[31:16], 1'b1);

		// back-to-back traffic at the reset weights
		test_random_traffic(0, 0, 180, DEF_RISE, DEF_FALL, DEF_PEAK_STEP, 1'b0);

		drain_results();
		// idle past the pipeline depth to catch any stray result
		repeat (8) @(posedge clk);

		$display("covered %0d band items and %0d checked results across three stall mixes,",
			items_sent, results_checked);
		$display("with %0d register writes including weight extremes and an unused index",
			reg_writes);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches", errors);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/bls_pkg.sv
rtl/bls_level.sv
rtl/bls_store.sv
rtl/band_level_smoother_peak_hold_unit.sv
tb/tb_band_level_smoother_peak_hold_unit.sv
